/* design/hrmp_pkg.sv */
// Package for the heart rate measurement parser.
// Holds the item and result structs, flag bit positions and command codes.
// No dependencies; imported by every module of the block except hrmp_checker.
`timescale 1ns / 1ps

package hrmp_pkg;

  // Command carried in tuser of the input channel
  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Bit positions inside the flag byte
  localparam int FLAG_RATE16_BIT = 0;   // 0x01: 16-bit rate
  localparam int FLAG_ENERGY_BIT = 3;   // 0x08: energy field present
  localparam int FLAG_RR_BIT     = 4;   // 0x10: RR intervals present

  // Packet byte counter saturates here
  localparam logic [5:0] INDEX_MAX = 6'd63;

  // RR conversion: raw * 1000 / 1024
  localparam logic [9:0] RR_MS_SCALE = 10'd1000;
  localparam int         RR_SHIFT    = 10;

  // One input item
  typedef struct packed {
    logic       cmd;
    logic [7:0] byte_value;
    logic       last_byte;
  } hrmp_item_t;

  // One result item
  typedef struct packed {
    logic [15:0] heart_rate;
    logic [15:0] rr_ms;
    logic        packet_accepted;
  } hrmp_result_t;

endpackage

/* design/hrmp_in_reg.sv */
// Input register of the heart rate measurement parser.
// Captures one transfer from the input channel; depends on hrmp_pkg.
`timescale 1ns / 1ps

module hrmp_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hrmp_pkg::hrmp_item_t in_item,
  output logic              hold_valid,
  output hrmp_pkg::hrmp_item_t hold_item,
  input  logic              hold_take
);
  import hrmp_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  hrmp_item_t item_r;

  // Accept when empty or when the held item leaves this cycle
  assign in_ready  = !valid_r || hold_take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load the payload on each transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;

endmodule

/* design/hrmp_parser.sv */
// Packet parser and kept-value state of the heart rate measurement parser.
// Updates per-packet state for each item and forms the result; uses hrmp_pkg.
`timescale 1ns / 1ps

module hrmp_parser #(
  parameter int MAX_PACKET = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  hold_valid,
  input  hrmp_pkg::hrmp_item_t  hold_item,
  output logic                  hold_take,
  input  logic                  slot_free,
  output logic                  res_valid,
  output hrmp_pkg::hrmp_result_t res
);
  import hrmp_pkg::*;

  localparam logic [5:0] MAX_POS = 6'(MAX_PACKET);

  logic [5:0]  byte_index_r,      byte_index_nxt;
  logic [7:0]  flag_bits_r,       flag_bits_nxt;
  logic [15:0] pending_rate_r,    pending_rate_nxt;
  logic [7:0]  rr_low_byte_r,     rr_low_byte_nxt;
  logic [15:0] pending_rr_r,      pending_rr_nxt;
  logic        pending_rr_seen_r, pending_rr_seen_nxt;
  logic [15:0] kept_rate_r,       kept_rate_nxt;
  logic [15:0] kept_rr_r,         kept_rr_nxt;

  logic        is_clear;
  logic        is_last;
  logic [5:0]  pos;
  logic        rate16;
  logic [2:0]  rr_start;
  logic        in_rr_area;
  logic        rr_high;
  logic [25:0] rr_product;
  logic [15:0] rr_ms_val;
  logic        accepted;

  assign is_clear = (hold_item.cmd == CMD_CLEAR);
  assign is_last  = hold_item.last_byte;
  assign pos      = byte_index_r;

  // Only a last packet byte needs the result slot
  assign hold_take = hold_valid && (is_clear || !is_last || slot_free);
  assign res_valid = hold_take && !is_clear && is_last;

  // Locate the RR area from the flag byte
  assign rate16     = flag_bits_r[FLAG_RATE16_BIT];
  assign rr_start   = (rate16 ? 3'd3 : 3'd2) + (flag_bits_r[FLAG_ENERGY_BIT] ? 3'd2 : 3'd0);
  assign in_rr_area = flag_bits_r[FLAG_RR_BIT] && (pos >= {3'd0, rr_start});
  assign rr_high    = pos[0] ^ rr_start[0];

  // Convert the raw RR pair to milliseconds
  assign rr_product = 26'({hold_item.byte_value, rr_low_byte_r}) * 26'(RR_MS_SCALE);
  assign rr_ms_val  = rr_product[RR_SHIFT +: 16];

  // Next state for one item
  always_comb begin
    byte_index_nxt      = byte_index_r;
    flag_bits_nxt       = flag_bits_r;
    pending_rate_nxt    = pending_rate_r;
    rr_low_byte_nxt     = rr_low_byte_r;
    pending_rr_nxt      = pending_rr_r;
    pending_rr_seen_nxt = pending_rr_seen_r;
    kept_rate_nxt       = kept_rate_r;
    kept_rr_nxt         = kept_rr_r;
    accepted            = 1'b0;

    if (hold_take) begin
      if (is_clear) begin
        // Drop any partial packet and zero the kept values
        kept_rate_nxt  = 16'd0;
        kept_rr_nxt    = 16'd0;
        byte_index_nxt = 6'd0;
      end else begin
        // Parse bytes up to the packet limit
        if (pos < MAX_POS) begin
          if (pos == 6'd0) begin
            flag_bits_nxt       = hold_item.byte_value;
            pending_rate_nxt    = 16'd0;
            pending_rr_nxt      = 16'd0;
            pending_rr_seen_nxt = 1'b0;
            rr_low_byte_nxt     = 8'd0;
          end else if (pos == 6'd1) begin
            pending_rate_nxt = {8'd0, hold_item.byte_value};
          end else if (pos == 6'd2 && rate16) begin
            pending_rate_nxt = pending_rate_r | {hold_item.byte_value, 8'd0};
          end else if (in_rr_area) begin
            if (!rr_high) begin
              rr_low_byte_nxt = hold_item.byte_value;
            end else begin
              pending_rr_nxt      = rr_ms_val;
              pending_rr_seen_nxt = 1'b1;
            end
          end
        end

        if (!is_last) begin
          // Advance the byte counter, saturating
          if (byte_index_r < INDEX_MAX) begin
            byte_index_nxt = byte_index_r + 6'd1;
          end
        end else begin
          // Commit a packet of valid length
          if (pos >= 6'd1 && pos < MAX_POS) begin
            accepted      = 1'b1;
            kept_rate_nxt = pending_rate_nxt;
            if (pending_rr_seen_nxt) begin
              kept_rr_nxt = pending_rr_nxt;
            end
          end
          byte_index_nxt = 6'd0;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r      <= 6'd0;
      flag_bits_r       <= 8'd0;
      pending_rate_r    <= 16'd0;
      rr_low_byte_r     <= 8'd0;
      pending_rr_r      <= 16'd0;
      pending_rr_seen_r <= 1'b0;
      kept_rate_r       <= 16'd0;
      kept_rr_r         <= 16'd0;
    end else begin
      byte_index_r      <= byte_index_nxt;
      flag_bits_r       <= flag_bits_nxt;
      pending_rate_r    <= pending_rate_nxt;
      rr_low_byte_r     <= rr_low_byte_nxt;
      pending_rr_r      <= pending_rr_nxt;
      pending_rr_seen_r <= pending_rr_seen_nxt;
      kept_rate_r       <= kept_rate_nxt;
      kept_rr_r         <= kept_rr_nxt;
    end
  end

  // Report the kept values after this item
  assign res.heart_rate      = kept_rate_nxt;
  assign res.rr_ms           = kept_rr_nxt;
  assign res.packet_accepted = accepted;

endmodule

/* design/hrmp_out_reg.sv */
// Result register of the heart rate measurement parser.
// Holds one result until the output transfer; depends on hrmp_pkg.
`timescale 1ns / 1ps

module hrmp_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_valid,
  input  hrmp_pkg::hrmp_result_t res,
  output logic                   slot_free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output hrmp_pkg::hrmp_result_t out_res
);
  import hrmp_pkg::*;

  logic         valid_r;
  logic         valid_nxt;
  hrmp_result_t res_r;

  // Slot is free when empty or drained this cycle
  assign slot_free = !valid_r || out_ready;
  assign valid_nxt = res_valid || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load a new result; the parser only issues one into a free slot
  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

/* design/heart_rate_measurement_parser_core.sv */
// Top level of the heart rate measurement parser.
// Instantiates hrmp_in_reg, hrmp_parser and hrmp_out_reg; uses hrmp_pkg.
//
//  Channel | Direction | tdata (low bit up)            | tuser           | tlast
//  in_     | slave     | byte_value[7:0]               | cmd             | last_byte
//  out_    | master    | heart_rate[15:0], rr_ms[15:0] | packet_accepted | -
//
// One item per cycle sustained while the output accepts; the last byte of a
// packet reaches the output through the input register, then the result register.
// The parser state updates in a single pass per held item.
// Reset (rst_n low, synchronous) zeroes all state and empties both registers.
// An output stall holds back only a last packet byte, which then blocks the
// input behind it; other bytes and clear commands keep flowing.
`timescale 1ns / 1ps

module heart_rate_measurement_parser_core #(
  parameter int MAX_PACKET = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tuser,   // [0] cmd
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] heart_rate, [31:16] rr_ms
  output logic        out_tuser   // [0] packet_accepted
);
  import hrmp_pkg::*;

  hrmp_item_t   in_item;
  hrmp_item_t   hold_item;
  logic         hold_valid;
  logic         hold_take;
  logic         slot_free;
  logic         res_valid;
  hrmp_result_t res;
  hrmp_result_t out_res;

  // Unpack the input transfer
  assign in_item.cmd        = in_tuser;
  assign in_item.byte_value = in_tdata;
  assign in_item.last_byte  = in_tlast;

  hrmp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .hold_take  (hold_take)
  );

  hrmp_parser #(
    .MAX_PACKET (MAX_PACKET)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .hold_take  (hold_take),
    .slot_free  (slot_free),
    .res_valid  (res_valid),
    .res        (res)
  );

  hrmp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .slot_free  (slot_free),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (out_res)
  );

  // Pack the result transfer
  assign out_tdata = {out_res.rr_ms, out_res.heart_rate};
  assign out_tuser = out_res.packet_accepted;

endmodule

/* design/hrmp_checker.sv */
// Port-level checks for the heart rate measurement parser.
// Bound to heart_rate_measurement_parser_core; sees its ports only.
`timescale 1ns / 1ps

module hrmp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Converted RR never exceeds the full-scale value
  a_rr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:16] <= 16'd63999)
    else $error("rr_ms out of range");

  // With the result slot empty the input never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result slot");

endmodule

bind heart_rate_measurement_parser_core hrmp_checker u_hrmp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
